>>> src/avlif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned item FIFO package
// Transaction payload types and operation codes shared by the FIFO modules.
// ----------------------------------------------------------------------------
package avlif_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic        has_byte;
    logic        last_byte;
    logic [5:0]  item_number;
    logic [11:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] payload_len;
    logic [11:0] item_offset;
    logic [7:0]  read_data;
    logic [12:0] bytes_held;
    logic [6:0]  items_held;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;     // Latch a new transaction and do its first step.
    logic pad_step;  // Write one zero pad byte.
    logic walk_step; // Consume one registered index entry.
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_pad;  // Close accepted and pad bytes remain.
    logic need_walk; // Pop or peek has index entries left to read.
  } stat_t;

endpackage

>>> src/avlif_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned item FIFO datapath
// Byte store, item index, positions and the per-transaction work registers.
// ----------------------------------------------------------------------------
module avlif_datapath #(
  parameter int DATA_BYTES  = 4096,
  parameter int ENTRIES     = 64,
  parameter int ALIGN_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avlif_pkg::in_item_t in_i,
  input  avlif_pkg::ctrl_t    ctrl_i,
  output avlif_pkg::stat_t    stat_o,
  output avlif_pkg::out_item_t res_o
);
  import avlif_pkg::*;

  localparam int PW = $clog2(DATA_BYTES + 1);
  localparam int AW = $clog2(DATA_BYTES);
  localparam int EW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int CW = $clog2(ALIGN_BYTES + 1);

  logic [7:0]    store_q [DATA_BYTES];
  logic [PW-1:0] alen_q  [ENTRIES];
  logic [CW-1:0] pad_q   [ENTRIES];

  logic [PW-1:0] wpos_q, rpos_q, plen_q;
  logic [LW-1:0] phase_q;
  logic [EW-1:0] head_q, tail_q;
  logic          ovf_q;

  in_item_t      cur_q;
  logic [1:0]    stat_q;
  logic [12:0]   size_q;
  logic [PW-1:0] off_q;
  logic [7:0]    rdata_q;
  logic [PW-1:0] pad_addr_q;
  logic [CW-1:0] pad_left_q;
  logic [EW-1:0] walk_idx_q;
  logic [6:0]    walk_left_q;
  logic          need_pad_q, need_walk_q;
  logic [PW-1:0] idx_alen_q;
  logic [CW-1:0] idx_pad_q;
  logic [IW-1:0] idx_raddr;

  // Close arithmetic on the length after this transaction's byte.
  logic          byte_ok;
  logic [PW-1:0] len_new;
  logic [LW-1:0] phase_new;
  logic [CW-1:0] pad_new;
  logic [PW:0]   al_new;
  logic          ovf_new;
  logic          do_close;
  logic          fits;
  logic [EW-1:0] held_items;

  assign byte_ok  = in_i.has_byte && ({1'b0, plen_q} < ({1'b0, PW'(DATA_BYTES)} - {1'b0, wpos_q}));
  assign len_new  = byte_ok ? plen_q + PW'(1) : plen_q;
  // The phase follows the pending length modulo the alignment, so the pad needs no divider.
  assign phase_new = byte_ok ? ((phase_q == LW'(ALIGN_BYTES - 1)) ? '0 : phase_q + LW'(1))
                             : phase_q;
  assign pad_new  = (phase_new == '0) ? '0 : CW'(ALIGN_BYTES) - CW'(phase_new);
  assign ovf_new  = ovf_q || (in_i.has_byte && !byte_ok);
  assign al_new   = (PW+1)'(len_new) + (PW+1)'(pad_new);
  assign do_close = in_i.last_byte || !in_i.has_byte;
  assign fits     = !ovf_new && (tail_q < EW'(ENTRIES)) &&
                    (al_new <= (PW+1)'(DATA_BYTES) - (PW+1)'(wpos_q));
  assign held_items = tail_q - head_q;

  // Byte store: one write port shared by bytes and padding, one read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && in_i.kind == KIND_PUSH && byte_ok) begin
      store_q[AW'(wpos_q + plen_q)] <= in_i.byte_value;
    end else if (ctrl_i.pad_step) begin
      store_q[AW'(pad_addr_q)] <= 8'd0;
    end
    if (ctrl_i.start) begin
      rdata_q <= store_q[AW'(in_i.read_address)];
    end
  end

  // Index: written at the tail on a close that fits, read one registered entry per cycle.
  assign idx_raddr = ctrl_i.start ? IW'(head_q) : IW'(walk_idx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && in_i.kind == KIND_PUSH && do_close && fits) begin
      alen_q[IW'(tail_q)] <= PW'(al_new);
      pad_q[IW'(tail_q)]  <= pad_new;
    end
    idx_alen_q <= alen_q[idx_raddr];
    idx_pad_q  <= pad_q[idx_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      rpos_q      <= '0;
      plen_q      <= '0;
      phase_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ovf_q       <= 1'b0;
      need_pad_q  <= 1'b0;
      need_walk_q <= 1'b0;
      pad_left_q  <= '0;
      walk_left_q <= '0;
    end else if (ctrl_i.start) begin
      need_pad_q  <= 1'b0;
      need_walk_q <= 1'b0;
      unique case (kind_e'(in_i.kind))
        KIND_PUSH: begin
          if (do_close) begin
            plen_q  <= '0;
            phase_q <= '0;
            ovf_q   <= 1'b0;
            if (fits) begin
              tail_q     <= tail_q + EW'(1);
              wpos_q     <= wpos_q + PW'(al_new);
              pad_addr_q <= wpos_q + len_new;
              pad_left_q <= pad_new;
              need_pad_q <= (pad_new != '0);
            end
          end else begin
            plen_q  <= len_new;
            phase_q <= phase_new;
            ovf_q   <= ovf_new;
          end
        end
        KIND_POP: begin
          walk_left_q <= '0;
          need_walk_q <= (head_q < tail_q);
        end
        KIND_PEEK: begin
          walk_idx_q  <= head_q + EW'(1);
          walk_left_q <= 7'(in_i.item_number);
          need_walk_q <= (EW'(in_i.item_number) < held_items);
        end
        default: begin
        end
      endcase
    end else begin
      if (ctrl_i.pad_step) begin
        pad_addr_q <= pad_addr_q + PW'(1);
        pad_left_q <= pad_left_q - CW'(1);
        need_pad_q <= (pad_left_q != CW'(1));
      end
      if (ctrl_i.walk_step) begin
        if (walk_left_q != 7'd0) begin
          walk_idx_q  <= walk_idx_q + EW'(1);
          walk_left_q <= walk_left_q - 7'd1;
        end else begin
          need_walk_q <= 1'b0;
          // The registered entry now holds the oldest item for a pop.
          if (cur_q.kind == KIND_POP) begin
            if (head_q + EW'(1) == tail_q) begin
              head_q <= '0;
              tail_q <= '0;
              if (plen_q == '0 && !ovf_q) begin
                rpos_q <= '0;
                wpos_q <= '0;
              end else begin
                rpos_q <= wpos_q;
              end
            end else begin
              head_q <= head_q + EW'(1);
              rpos_q <= rpos_q + idx_alen_q;
            end
          end
        end
      end
    end
  end

  // Per-transaction result fields.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cur_q  <= in_i;
      stat_q <= STAT_OK;
      size_q <= '0;
      off_q  <= rpos_q;
      unique case (kind_e'(in_i.kind))
        KIND_PUSH: if (do_close && !fits) stat_q <= STAT_FULL;
        KIND_POP: begin
          if (head_q >= tail_q) stat_q <= STAT_EMPTY;
        end
        KIND_PEEK: begin
          if (EW'(in_i.item_number) >= held_items) stat_q <= STAT_EMPTY;
        end
        KIND_READ: begin
          if (32'(in_i.read_address) >= DATA_BYTES) stat_q <= STAT_EMPTY;
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.walk_step) begin
      if (walk_left_q != 7'd0) begin
        off_q <= off_q + idx_alen_q;
      end else begin
        size_q <= 13'(idx_alen_q - PW'(idx_pad_q));
      end
    end
  end

  logic res_ok;
  assign res_ok = (stat_q == STAT_OK);

  always_comb begin
    res_o             = '0;
    res_o.status      = stat_q;
    res_o.bytes_held  = 13'(wpos_q - rpos_q);
    res_o.items_held  = 7'(tail_q - head_q);
    if (res_ok && cur_q.kind == KIND_POP) res_o.payload_len = size_q;
    if (res_ok && cur_q.kind == KIND_PEEK) begin
      res_o.payload_len = size_q;
      res_o.item_offset = 12'(off_q);
    end
    if (res_ok && cur_q.kind == KIND_READ) res_o.read_data = rdata_q;
  end

  assign stat_o.need_pad  = need_pad_q;
  assign stat_o.need_walk = need_walk_q;
endmodule

>>> src/avlif_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned item FIFO controller
// Sequences each transaction: start, any padding or index walk, then result.
// ----------------------------------------------------------------------------
module avlif_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  avlif_pkg::stat_t stat_i,
  output avlif_pkg::ctrl_t ctrl_o
);
  import avlif_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   start;
  logic   busy;

  assign busy  = stat_i.need_pad || stat_i.need_walk;
  // A new transaction may start while the result register is empty or being taken.
  assign start = in_valid_i && (state_q == ST_IDLE || (state_q == ST_OUT && !out_stall_i));
  assign in_stall_o = !(state_q == ST_IDLE || (state_q == ST_OUT && !out_stall_i));
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.start     = start;
    ctrl_o.pad_step  = (state_q == ST_WORK) && stat_i.need_pad;
    ctrl_o.walk_step = (state_q == ST_WORK) && stat_i.need_walk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (start) state_q <= ST_WORK;
        ST_WORK: if (!busy) state_q <= ST_OUT;
        ST_OUT: begin
          if (start) state_q <= ST_WORK;
          else if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> src/aligned_variable_length_item_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned variable-length item FIFO
// Each accepted transaction passes a work state before its result: it writes the
// zero pad bytes on a closing push, reads the oldest index entry on a pop that
// removes an item, and walks the registered index up to item n on an in-range peek.
// A new transaction is accepted only when idle or while the result is being taken;
// the single byte-store write port and the serial registered index walk set this.
// Reset clears the write, read and pending positions, the item counts and control;
// store and index contents stay undefined.
module aligned_variable_length_item_fifo #(
  parameter int DATA_BYTES  = 4096,
  parameter int ENTRIES     = 64,
  parameter int ALIGN_BYTES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  avlif_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output avlif_pkg::out_item_t out_data_o
);
  import avlif_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  avlif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  avlif_datapath #(
    .DATA_BYTES (DATA_BYTES),
    .ENTRIES    (ENTRIES),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_data_i),
    .ctrl_i(ctrl),
    .stat_o(stat),
    .res_o (out_data_o)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.pad_step || ctrl.walk_step) |-> in_stall_o)
    else $error("input accepted during multi-cycle work");

  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.items_held) <= ENTRIES)
    else $error("item count exceeds index depth");
endmodule
